// File: rtl/core/grid_tile_layout_defines.svh
// Assertion macros used by the grid tile layout top level
`ifndef GRID_TILE_LAYOUT_DEFINES_SVH
`define GRID_TILE_LAYOUT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define GTL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid tile layout: same-cycle check failed");

// Next-cycle implication, disabled in reset
`define GTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid tile layout: next-cycle check failed");

`endif

// File: rtl/core/gtl_pkg.sv
// Types, constants and helper functions of the grid tile layout block
package gtl_pkg;

   localparam int COORD_W = 16;
   localparam int CNT_W = 7;
   localparam int IDX_W = 6;
   localparam int NB_W = 8;
   localparam int DIR_W = 2;
   localparam int GRID_W = 4;
   localparam int GRID_MAX = 8;
   localparam int DIV_W = 16;
   localparam int MAX_CLIENTS_DEF = 64;

   typedef enum logic {
      OP_LAYOUT = 1'b0,
      OP_NEIGHBOUR = 1'b1
   } op_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_UP = 2'd0,
      DIR_DOWN = 2'd1,
      DIR_LEFT = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      DIV_ROWS = 2'd0,
      DIV_START = 2'd1,
      DIV_WIDTH = 2'd2,
      DIV_HEIGHT = 2'd3
   } div_sel_type;

   typedef struct packed {
      logic load;
      logic div_go;
      div_sel_type div_sel;
      logic emit_tile;
      logic emit_nb;
      logic csr_open;
   } ctrl_cmd_type;

   typedef struct packed {
      logic op_nbr;
      logic n_zero;
      logic div_done;
      logic div_running;
      logic tile_last;
   } dp_status_type;

   // Smallest c with c*c >= n
   function automatic logic [GRID_W-1:0] grid_cols(input logic [CNT_W-1:0] n);
      logic [GRID_W-1:0] res;
      res = GRID_W'(GRID_MAX);
      for (int k = GRID_MAX; k >= 0; k--) begin
         if ((k * k) >= int'(n)) begin
            res = GRID_W'(k);
         end
      end
      return res;
   endfunction

endpackage

// File: rtl/core/grid_tile_layout.sv
// Top level of the near-square grid tile layout block
//
//   channel    direction  handshake                 carries
//   request    in         start / busy              op, rectangle, count, direction, index
//   response   out        rsp_strobe (no stall)     tile corner and size, indices, last
//   csr        in         csr_valid / csr_ready     gapless fill bit
//
// A request is taken when start is high and busy low; busy stays high until its last word.
// A layout runs three divisions (rows, tile width, tile height), a neighbour query two (rows, start
// index), on one shared 16-bit divider, one quotient bit per cycle; grid_cols gives the column count.
// Tiles then leave one word per cycle. N = 0 layouts give no word.
// Reset is synchronous; it clears the controller, divider control, strobe and fill bit.
// The receiver cannot stall, so every word shows for exactly one cycle.
module grid_tile_layout #(
   parameter int MAX_CLIENTS = gtl_pkg::MAX_CLIENTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic signed [gtl_pkg::COORD_W-1:0] req_rect_x,
   input  logic signed [gtl_pkg::COORD_W-1:0] req_rect_y,
   input  logic [gtl_pkg::COORD_W-1:0]        req_rect_width,
   input  logic [gtl_pkg::COORD_W-1:0]        req_rect_height,
   input  logic [gtl_pkg::CNT_W-1:0]          req_client_count,
   input  logic [gtl_pkg::DIR_W-1:0]          req_direction,
   input  logic [gtl_pkg::IDX_W-1:0]          req_start_index,
   output logic                               rsp_strobe,
   output logic signed [gtl_pkg::COORD_W-1:0] rsp_tile_x,
   output logic signed [gtl_pkg::COORD_W-1:0] rsp_tile_y,
   output logic [gtl_pkg::COORD_W-1:0]        rsp_tile_width,
   output logic [gtl_pkg::COORD_W-1:0]        rsp_tile_height,
   output logic [gtl_pkg::IDX_W-1:0]          rsp_client_index,
   output logic signed [gtl_pkg::NB_W-1:0]    rsp_neighbour_index,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_data
);
   import gtl_pkg::*;

   `include "grid_tile_layout_defines.svh"

   ctrl_cmd_type  cmd;
   dp_status_type status;

   gtl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   gtl_datapath #(
      .MAX_CLIENTS (MAX_CLIENTS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_valid           (csr_valid),
      .csr_data            (csr_data),
      .req_op              (req_op),
      .req_rect_x          (req_rect_x),
      .req_rect_y          (req_rect_y),
      .req_rect_width      (req_rect_width),
      .req_rect_height     (req_rect_height),
      .req_client_count    (req_client_count),
      .req_direction       (req_direction),
      .req_start_index     (req_start_index),
      .rsp_strobe          (rsp_strobe),
      .rsp_tile_x          (rsp_tile_x),
      .rsp_tile_y          (rsp_tile_y),
      .rsp_tile_width      (rsp_tile_width),
      .rsp_tile_height     (rsp_tile_height),
      .rsp_client_index    (rsp_client_index),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_last            (rsp_last)
   );

   assign csr_ready = cmd.csr_open;

   // an accepted request keeps the block busy in the next cycle
   `GTL_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // tiles of one layout leave back to back
   `GTL_ASSERT_NEXT(a_tiles_contiguous, clock, reset, rsp_strobe && !rsp_last, rsp_strobe)
   // a nonzero neighbour answer is always the only and final word
   `GTL_ASSERT_NOW(a_nbr_last, clock, reset, rsp_strobe && (rsp_neighbour_index != '0), rsp_last)
   // the divider only runs while a request is in hand
   `GTL_ASSERT_NOW(a_div_idle, clock, reset, !busy, !status.div_running)

endmodule

// File: rtl/core/gtl_div.sv
// Shared restoring divider, one quotient bit per cycle
module gtl_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [gtl_pkg::DIV_W-1:0]  dividend,
   input  logic [gtl_pkg::GRID_W-1:0] divisor,
   output logic [gtl_pkg::DIV_W-1:0]  quotient,
   output logic [gtl_pkg::GRID_W-1:0] remainder,
   output logic                       done,
   output logic                       running
);
   import gtl_pkg::*;

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [GRID_W-1:0] rem_ff, rem_in;
   logic [GRID_W-1:0] dsr_ff, dsr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [GRID_W:0]   trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits = trial >= {1'b0, dsr_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      step_in = step_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (go) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         step_in = STEP_W'(DIV_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? GRID_W'(trial - {1'b0, dsr_ff}) : GRID_W'(trial);
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         step_ff <= '0;
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign remainder = rem_ff;
   assign done = done_ff;
   assign running = run_ff;

endmodule

// File: rtl/core/gtl_datapath.sv
// Grid layout datapath: request registers, grid sizes, tile walk and result word
module gtl_datapath #(
   parameter int MAX_CLIENTS = gtl_pkg::MAX_CLIENTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gtl_pkg::ctrl_cmd_type             cmd,
   output gtl_pkg::dp_status_type            status,
   input  logic                              csr_valid,
   input  logic                              csr_data,
   input  logic                              req_op,
   input  logic signed [gtl_pkg::COORD_W-1:0] req_rect_x,
   input  logic signed [gtl_pkg::COORD_W-1:0] req_rect_y,
   input  logic [gtl_pkg::COORD_W-1:0]       req_rect_width,
   input  logic [gtl_pkg::COORD_W-1:0]       req_rect_height,
   input  logic [gtl_pkg::CNT_W-1:0]         req_client_count,
   input  logic [gtl_pkg::DIR_W-1:0]         req_direction,
   input  logic [gtl_pkg::IDX_W-1:0]         req_start_index,
   output logic                              rsp_strobe,
   output logic signed [gtl_pkg::COORD_W-1:0] rsp_tile_x,
   output logic signed [gtl_pkg::COORD_W-1:0] rsp_tile_y,
   output logic [gtl_pkg::COORD_W-1:0]       rsp_tile_width,
   output logic [gtl_pkg::COORD_W-1:0]       rsp_tile_height,
   output logic [gtl_pkg::IDX_W-1:0]         rsp_client_index,
   output logic signed [gtl_pkg::NB_W-1:0]   rsp_neighbour_index,
   output logic                              rsp_last
);
   import gtl_pkg::*;

   // request word
   logic                op_ff;
   logic [COORD_W-1:0]  rx_ff, ry_ff, rw_ff, rh_ff;
   logic [CNT_W-1:0]    n_ff;
   dir_type             dir_ff;
   logic [IDX_W-1:0]    start_ff;
   logic [GRID_W-1:0]   cols_ff;
   logic                gapless_ff;

   // division results
   div_sel_type         sel_ff;
   logic [GRID_W-1:0]   rows_ff;
   logic [IDX_W-1:0]    sq_ff;
   logic [GRID_W-1:0]   sr_ff;
   logic [COORD_W-1:0]  tw_ff, th_ff;
   logic [GRID_W-1:0]   wrem_ff, hrem_ff;

   // tile walk
   logic [IDX_W-1:0]    i_ff;
   logic [GRID_W-1:0]   r_ff, c_ff;
   logic [COORD_W-1:0]  xoff_ff, yoff_ff;

   // result word
   logic                strobe_ff;
   logic [COORD_W-1:0]  out_x_ff, out_y_ff, out_w_ff, out_h_ff;
   logic [IDX_W-1:0]    out_idx_ff;
   logic [NB_W-1:0]     out_nb_ff;
   logic                out_last_ff;

   logic [CNT_W-1:0]    n_sat;
   logic [DIV_W-1:0]    div_dividend;
   logic [GRID_W-1:0]   div_divisor;
   logic [DIV_W-1:0]    div_quo;
   logic [GRID_W-1:0]   div_rem;
   logic                div_done;
   logic                div_running;

   logic                tile_last, col_last, row_last;
   logic [COORD_W-1:0]  tile_w, tile_h;
   logic [NB_W-1:0]     s8, ci8, nb_val, nb_down;

   assign n_sat = (req_client_count > CNT_W'(MAX_CLIENTS)) ? CNT_W'(MAX_CLIENTS)
                                                           : req_client_count;

   always_comb begin
      div_dividend = '0;
      div_divisor = cols_ff;
      unique case (cmd.div_sel)
         DIV_ROWS: begin
            div_dividend = DIV_W'(n_ff) + DIV_W'(cols_ff) - DIV_W'(1);
         end
         DIV_START: begin
            div_dividend = DIV_W'(start_ff);
         end
         DIV_WIDTH: begin
            div_dividend = rw_ff;
         end
         DIV_HEIGHT: begin
            div_dividend = rh_ff;
            div_divisor = rows_ff;
         end
         default: begin
            div_dividend = '0;
         end
      endcase
   end

   gtl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (cmd.div_go),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done),
      .running   (div_running)
   );

   // tile geometry
   assign tile_last = ({1'b0, i_ff} + CNT_W'(1)) == n_ff;
   assign col_last = ({1'b0, c_ff} + (GRID_W + 1)'(1)) == {1'b0, cols_ff};
   assign row_last = ({1'b0, r_ff} + (GRID_W + 1)'(1)) == {1'b0, rows_ff};

   always_comb begin
      if (gapless_ff && tile_last && !col_last) begin
         tile_w = rw_ff - xoff_ff;
      end else if (col_last) begin
         tile_w = tw_ff + COORD_W'(wrem_ff);
      end else begin
         tile_w = tw_ff;
      end
      tile_h = row_last ? th_ff + COORD_W'(hrem_ff) : th_ff;
   end

   // neighbour index
   assign s8 = NB_W'(start_ff);
   assign ci8 = NB_W'(cols_ff);
   assign nb_down = (gapless_ff && ($signed(s8 + ci8) >= $signed(NB_W'(n_ff))) &&
                     (({1'b0, sq_ff} + (IDX_W + 1)'(2)) == (IDX_W + 1)'(rows_ff)))
                    ? NB_W'(n_ff) - NB_W'(1) : s8 + ci8;

   always_comb begin
      nb_val = '1;
      if (n_ff != '0) begin
         unique case (dir_ff)
            DIR_UP: begin
               nb_val = s8 - ci8;
            end
            DIR_DOWN: begin
               nb_val = nb_down;
            end
            DIR_LEFT: begin
               nb_val = (sr_ff != '0) ? s8 - NB_W'(1) : '1;
            end
            DIR_RIGHT: begin
               nb_val = (({1'b0, sr_ff} + (GRID_W + 1)'(1)) < {1'b0, cols_ff})
                        ? s8 + NB_W'(1) : '1;
            end
            default: begin
               nb_val = '1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         rx_ff <= req_rect_x;
         ry_ff <= req_rect_y;
         rw_ff <= req_rect_width;
         rh_ff <= req_rect_height;
         n_ff <= n_sat;
         dir_ff <= dir_type'(req_direction);
         start_ff <= req_start_index;
         cols_ff <= grid_cols(n_sat);
         i_ff <= '0;
         r_ff <= '0;
         c_ff <= '0;
         xoff_ff <= '0;
         yoff_ff <= '0;
      end else if (cmd.emit_tile) begin
         // advance along the row, wrap to the next row at the last column
         i_ff <= i_ff + IDX_W'(1);
         if (col_last) begin
            c_ff <= '0;
            r_ff <= r_ff + GRID_W'(1);
            xoff_ff <= '0;
            yoff_ff <= yoff_ff + th_ff;
         end else begin
            c_ff <= c_ff + GRID_W'(1);
            xoff_ff <= xoff_ff + tw_ff;
         end
      end

      if (cmd.div_go) begin
         sel_ff <= cmd.div_sel;
      end

      if (div_done) begin
         case (sel_ff)
            DIV_ROWS: rows_ff <= GRID_W'(div_quo);
            DIV_START: begin
               sq_ff <= IDX_W'(div_quo);
               sr_ff <= div_rem;
            end
            DIV_WIDTH: begin
               tw_ff <= div_quo;
               wrem_ff <= div_rem;
            end
            default: begin
               th_ff <= div_quo;
               hrem_ff <= div_rem;
            end
         endcase
      end

      if (cmd.emit_tile) begin
         out_x_ff <= rx_ff + xoff_ff;
         out_y_ff <= ry_ff + yoff_ff;
         out_w_ff <= tile_w;
         out_h_ff <= tile_h;
         out_idx_ff <= i_ff;
         out_nb_ff <= '0;
         out_last_ff <= tile_last;
      end else if (cmd.emit_nb) begin
         out_x_ff <= '0;
         out_y_ff <= '0;
         out_w_ff <= '0;
         out_h_ff <= '0;
         out_idx_ff <= '0;
         out_nb_ff <= nb_val;
         out_last_ff <= 1'b1;
      end

      if (reset) begin
         gapless_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_valid && cmd.csr_open) begin
            gapless_ff <= csr_data;
         end
         strobe_ff <= cmd.emit_tile || cmd.emit_nb;
      end
   end

   always_comb begin
      status.op_nbr = op_ff == OP_NEIGHBOUR;
      status.n_zero = n_ff == '0;
      status.div_done = div_done;
      status.div_running = div_running;
      status.tile_last = tile_last;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_tile_x = $signed(out_x_ff);
   assign rsp_tile_y = $signed(out_y_ff);
   assign rsp_tile_width = out_w_ff;
   assign rsp_tile_height = out_h_ff;
   assign rsp_client_index = out_idx_ff;
   assign rsp_neighbour_index = $signed(out_nb_ff);
   assign rsp_last = out_last_ff;

endmodule

// File: rtl/core/gtl_ctrl.sv
// Grid layout controller: sequences divisions, tile walk and neighbour answer
module gtl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  gtl_pkg::dp_status_type status,
   output gtl_pkg::ctrl_cmd_type  cmd
);
   import gtl_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_CHECK   = 8'b0000_0010,
      ST_DROWS   = 8'b0000_0100,
      ST_DSTART  = 8'b0000_1000,
      ST_DWIDTH  = 8'b0001_0000,
      ST_DHEIGHT = 8'b0010_0000,
      ST_TILE    = 8'b0100_0000,
      ST_NBR     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!status.n_zero) begin
               state_in = ST_DROWS;
            end else if (status.op_nbr) begin
               state_in = ST_NBR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DROWS: begin
            if (status.div_done) state_in = status.op_nbr ? ST_DSTART : ST_DWIDTH;
         end
         ST_DSTART: begin
            if (status.div_done) state_in = ST_NBR;
         end
         ST_DWIDTH: begin
            if (status.div_done) state_in = ST_DHEIGHT;
         end
         ST_DHEIGHT: begin
            if (status.div_done) state_in = ST_TILE;
         end
         ST_TILE: begin
            if (status.tile_last) state_in = ST_IDLE;
         end
         ST_NBR: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // decode the state into commands; launch the divider on entry to each division state
   always_comb begin
      cmd.load = (state_ff == ST_IDLE) && start;
      cmd.emit_tile = state_ff == ST_TILE;
      cmd.emit_nb = state_ff == ST_NBR;
      cmd.csr_open = state_ff == ST_IDLE;
      cmd.div_go = (state_in != state_ff) &&
                   ((state_in == ST_DROWS) || (state_in == ST_DSTART) ||
                    (state_in == ST_DWIDTH) || (state_in == ST_DHEIGHT));
      unique case (state_in)
         ST_DSTART:  cmd.div_sel = DIV_START;
         ST_DWIDTH:  cmd.div_sel = DIV_WIDTH;
         ST_DHEIGHT: cmd.div_sel = DIV_HEIGHT;
         default:    cmd.div_sel = DIV_ROWS;
      endcase
   end

   assign busy = state_ff != ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: tb/sv/grid_tile_layout_tb.sv
// Self-checking testbench for the grid tile layout block: layouts, neighbour queries, fill bit
module grid_tile_layout_tb;
   import gtl_pkg::*;

   localparam int HALF_PERIOD = 5;
   localparam int FULL_GRID = 64;
   localparam int SETTLE_CYCLES = 60;
   localparam int DRAIN_CYCLES = 150;
   localparam int QUIET_TAIL = 25;
   localparam int PHASE_ITEMS = 38;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct {
      bit                        is_csr;
      bit                        fill_bit;
      op_type                    op;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [COORD_W-1:0]        w;
      logic [COORD_W-1:0]        h;
      logic [CNT_W-1:0]          count;
      dir_type                   dir;
      logic [IDX_W-1:0]          idx;
   } job_type;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [COORD_W-1:0]        w;
      logic [COORD_W-1:0]        h;
      logic [IDX_W-1:0]          idx;
      logic signed [NB_W-1:0]    nb;
      logic                      last;
   } tile_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_op = 1'b0;
   logic signed [COORD_W-1:0] req_rect_x = '0;
   logic signed [COORD_W-1:0] req_rect_y = '0;
   logic [COORD_W-1:0]        req_rect_width = '0;
   logic [COORD_W-1:0]        req_rect_height = '0;
   logic [CNT_W-1:0]          req_client_count = '0;
   logic [DIR_W-1:0]          req_direction = '0;
   logic [IDX_W-1:0]          req_start_index = '0;
   logic                      rsp_strobe;
   logic signed [COORD_W-1:0] rsp_tile_x;
   logic signed [COORD_W-1:0] rsp_tile_y;
   logic [COORD_W-1:0]        rsp_tile_width;
   logic [COORD_W-1:0]        rsp_tile_height;
   logic [IDX_W-1:0]          rsp_client_index;
   logic signed [NB_W-1:0]    rsp_neighbour_index;
   logic                      rsp_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic                      csr_data = 1'b0;

   job_type       req_backlog[$];
   tile_word_type due_words[$];
   bit            fill_mirror = 1'b0;
   bit            req_taken = 1'b0;
   bit            csr_taken = 1'b0;
   int            gap_left = 0;
   int            settle_count = 0;
   int            fail_count = 0;
   int            cycle_count = 0;

   grid_tile_layout uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_rect_x          (req_rect_x),
      .req_rect_y          (req_rect_y),
      .req_rect_width      (req_rect_width),
      .req_rect_height     (req_rect_height),
      .req_client_count    (req_client_count),
      .req_direction       (req_direction),
      .req_start_index     (req_start_index),
      .rsp_strobe          (rsp_strobe),
      .rsp_tile_x          (rsp_tile_x),
      .rsp_tile_y          (rsp_tile_y),
      .rsp_tile_width      (rsp_tile_width),
      .rsp_tile_height     (rsp_tile_height),
      .rsp_client_index    (rsp_client_index),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic job_type mk_req(input op_type op, input int x, input int y, input int w,
                                      input int h, input int n, input int dir, input int idx);
      job_type j;
      j.is_csr = 1'b0;
      j.fill_bit = 1'b0;
      j.op = op;
      j.x = COORD_W'(x);
      j.y = COORD_W'(y);
      j.w = COORD_W'(w);
      j.h = COORD_W'(h);
      j.count = CNT_W'(n);
      j.dir = dir_type'(DIR_W'(dir));
      j.idx = IDX_W'(idx);
      return j;
   endfunction

   function automatic job_type mk_csr(input bit fill);
      job_type j;
      j = mk_req(OP_LAYOUT, 0, 0, 0, 0, 0, 0, 0);
      j.is_csr = 1'b1;
      j.fill_bit = fill;
      return j;
   endfunction

   function automatic job_type random_job();
      int pick;
      int n;
      pick = $urandom_range(0, 9);
      if (pick == 0) n = 0;
      else if (pick == 1) n = $urandom_range(65, 127);
      else n = $urandom_range(1, FULL_GRID);
      return mk_req(op_type'($urandom_range(0, 1)),
                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1920),
                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1080),
                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000),
                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000),
                    n, $urandom_range(0, 3),
                    $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 15));
   endfunction

   // Work out the words one accepted request must produce
   function automatic void place_request(input job_type j);
      int n, cols, rows, rw, rh, tw, th, w, h, k, r, c, st, nb;
      logic [COORD_W-1:0] x, y;
      tile_word_type t;
      n = (j.count > FULL_GRID) ? FULL_GRID : int'(j.count);
      cols = 0;
      while (cols * cols < n) cols++;
      rows = (cols == 0) ? 0 : (n + cols - 1) / cols;
      t.x = '0;
      t.y = '0;
      t.w = '0;
      t.h = '0;
      t.idx = '0;
      t.nb = '0;
      t.last = 1'b1;
      if (j.op == OP_NEIGHBOUR) begin
         nb = -1;
         st = int'(j.idx);
         if (cols != 0) begin
            case (j.dir)
               DIR_UP: nb = st - cols;
               DIR_DOWN: begin
                  nb = st + cols;
                  // clamp onto the stretched last client from the row above it
                  if (fill_mirror && nb >= n && st / cols == rows - 2) nb = n - 1;
               end
               DIR_LEFT: nb = (st % cols > 0) ? st - 1 : -1;
               default: nb = (st % cols < cols - 1) ? st + 1 : -1;
            endcase
         end
         t.nb = NB_W'(nb);
         due_words.push_back(t);
      end else if (n != 0) begin
         rw = int'(j.w);
         rh = int'(j.h);
         tw = rw / cols;
         th = rh / rows;
         k = 0;
         y = j.y;
         for (r = 0; r < rows; r++) begin
            h = th + ((r == rows - 1) ? rh % rows : 0);
            x = j.x;
            for (c = 0; c < cols && k < n; c++) begin
               if (fill_mirror && k == n - 1 && n % cols != 0) w = rw - c * tw;
               else if (c == cols - 1) w = tw + rw % cols;
               else w = tw;
               t.x = x;
               t.y = y;
               t.w = COORD_W'(w);
               t.h = COORD_W'(h);
               t.idx = IDX_W'(k);
               t.nb = '0;
               t.last = (k == n - 1);
               due_words.push_back(t);
               x = x + COORD_W'(tw);
               k++;
            end
            y = y + COORD_W'(th);
         end
      end
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: check response words, predict accepted requests, mirror the fill bit
   always @(posedge clock) begin
      tile_word_type want;
      if (reset) begin
         req_taken <= 1'b0;
         csr_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         csr_taken <= csr_valid && csr_ready;
         if (rsp_strobe) begin
            if (due_words.size() == 0) begin
               $error("response word with nothing outstanding");
               fail_count++;
            end else begin
               want = due_words.pop_front();
               check_field("tile_x", int'(want.x), int'(rsp_tile_x));
               check_field("tile_y", int'(want.y), int'(rsp_tile_y));
               check_field("tile_width", int'(want.w), int'(rsp_tile_width));
               check_field("tile_height", int'(want.h), int'(rsp_tile_height));
               check_field("client_index", int'(want.idx), int'(rsp_client_index));
               check_field("neighbour_index", int'(want.nb), int'(rsp_neighbour_index));
               check_field("last", int'(want.last), int'(rsp_last));
            end
         end
         if (csr_valid && csr_ready) fill_mirror = csr_data;
         if (start && !busy) begin
            place_request(mk_req(op_type'(req_op), req_rect_x, req_rect_y, req_rect_width,
                                 req_rect_height, req_client_count, req_direction,
                                 req_start_index));
         end
      end
   end

   // Driver: one request or register write at a time, with idle bursts
   always @(negedge clock) begin
      job_type j;
      if (!reset) begin
         if (start && !req_taken) begin
            // hold the request until it is taken
         end else if (csr_valid && !csr_taken) begin
            // hold the register write until it is taken
         end else if (gap_left != 0) begin
            start <= 1'b0;
            csr_valid <= 1'b0;
            gap_left--;
         end else if (req_backlog.size() == 0) begin
            start <= 1'b0;
            csr_valid <= 1'b0;
         end else if (req_backlog[0].is_csr) begin
            start <= 1'b0;
            // write only once the block has settled and every word is in
            if (due_words.size() != 0 || busy) settle_count = 0;
            else settle_count++;
            if (settle_count > SETTLE_CYCLES) begin
               j = req_backlog.pop_front();
               csr_valid <= 1'b1;
               csr_data <= j.fill_bit;
               settle_count = 0;
            end else begin
               csr_valid <= 1'b0;
            end
         end else begin
            j = req_backlog.pop_front();
            start <= 1'b1;
            csr_valid <= 1'b0;
            req_op <= j.op;
            req_rect_x <= j.x;
            req_rect_y <= j.y;
            req_rect_width <= j.w;
            req_rect_height <= j.h;
            req_client_count <= j.count;
            req_direction <= j.dir;
            req_start_index <= j.idx;
            if (req_backlog.size() > QUIET_TAIL && $urandom_range(0, 2) == 0)
               gap_left = $urandom_range(1, 13);
         end
      end
   end

   initial begin
      // fill bit clear after reset
      req_backlog.push_back(mk_req(OP_LAYOUT, 100, 200, 640, 480, 0, 0, 0));
      req_backlog.push_back(mk_req(OP_LAYOUT, -32768, -32768, 65535, 65535, 1, 0, 0));
      req_backlog.push_back(mk_req(OP_LAYOUT, 0, 0, 0, 0, 2, 0, 0));
      req_backlog.push_back(mk_req(OP_LAYOUT, 5, -7, 1001, 7, 5, 0, 0));
      req_backlog.push_back(mk_req(OP_LAYOUT, 32767, 32767, 65535, 65535, 64, 0, 0));
      req_backlog.push_back(mk_req(OP_LAYOUT, 0, 0, 640, 480, 127, 0, 0));
      req_backlog.push_back(mk_req(OP_LAYOUT, 30000, 0, 40000, 1000, 7, 0, 0));
      req_backlog.push_back(mk_req(OP_NEIGHBOUR, 0, 0, 0, 0, 0, DIR_DOWN, 5));
      req_backlog.push_back(mk_req(OP_NEIGHBOUR, 0, 0, 0, 0, 9, DIR_UP, 1));
      req_backlog.push_back(mk_req(OP_NEIGHBOUR, 0, 0, 0, 0, 9, DIR_DOWN, 7));
      req_backlog.push_back(mk_req(OP_NEIGHBOUR, 0, 0, 0, 0, 9, DIR_LEFT, 3));
      req_backlog.push_back(mk_req(OP_NEIGHBOUR, 0, 0, 0, 0, 9, DIR_RIGHT, 2));
      req_backlog.push_back(mk_req(OP_NEIGHBOUR, 0, 0, 0, 0, 5, DIR_RIGHT, 60));
      req_backlog.push_back(mk_req(OP_NEIGHBOUR, 0, 0, 0, 0, 127, DIR_LEFT, 63));
      // fill bit set: short last rows stretch, downward moves clamp
      req_backlog.push_back(mk_csr(1'b1));
      req_backlog.push_back(mk_req(OP_LAYOUT, 10, 10, 101, 51, 3, 0, 0));
      req_backlog.push_back(mk_req(OP_LAYOUT, -100, 50, 1920, 1080, 7, 0, 0));
      req_backlog.push_back(mk_req(OP_LAYOUT, 0, 0, 65535, 65535, 10, 0, 0));
      req_backlog.push_back(mk_req(OP_NEIGHBOUR, 0, 0, 0, 0, 7, DIR_DOWN, 4));
      req_backlog.push_back(mk_req(OP_NEIGHBOUR, 0, 0, 0, 0, 10, DIR_DOWN, 7));
      req_backlog.push_back(mk_req(OP_NEIGHBOUR, 0, 0, 0, 0, 4, DIR_DOWN, 2));
      req_backlog.push_back(mk_req(OP_LAYOUT, 1, 1, 800, 600, 64, 0, 0));
      req_backlog.push_back(mk_req(OP_LAYOUT, 0, 0, 1023, 767, 127, 0, 0));
      for (int p = 0; p < 4; p++) begin
         req_backlog.push_back(mk_csr(p % 2));
         repeat (PHASE_ITEMS) req_backlog.push_back(random_job());
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || start || csr_valid || due_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/gtl_pkg.sv
rtl/core/gtl_div.sv
rtl/core/gtl_datapath.sv
rtl/core/gtl_ctrl.sv
rtl/core/grid_tile_layout.sv
tb/sv/grid_tile_layout_tb.sv
